/* src/lagged_pearson_correlation_macros.svh */
// assertion macros for the lagged pearson correlation block
`ifndef LAGGED_PEARSON_CORRELATION_MACROS_SVH
`define LAGGED_PEARSON_CORRELATION_MACROS_SVH

// property that must hold in the same cycle as the enabling condition, outside reset
`define LPC_ASSERT_IMPL(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// property that must hold in the cycle after the enabling condition
`define LPC_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

/* src/lpc_pkg.sv */
// shared types and constants for the lagged pearson correlation block
`timescale 1ns / 1ps
package lpc_pkg;
  localparam int MaxLag     = 64;
  localparam int MaxRows    = 65536;
  localparam int SampleBits = 16;
  localparam int LagW       = $clog2(MaxLag);
  localparam int MagW       = $clog2(MaxLag + 1);
  localparam int CountW     = $clog2(MaxRows + 1);
  localparam int SumW       = CountW + SampleBits;
  localparam int SqW        = CountW + 2 * SampleBits - 1;
  localparam int CrossW     = CountW + 2 * SampleBits;
  localparam int CoefW      = 17;
  localparam int QueueDepth = 2;

  typedef logic signed [SampleBits-1:0] sample_t;

  // one finished stream, handed from the front to the back
  typedef struct packed {
    logic [CountW-1:0]      n;
    logic signed [SumW-1:0] sa;
    logic signed [SumW-1:0] sb;
    logic [SqW-1:0]         saa;
    logic [SqW-1:0]         sbb;
    logic signed [CrossW-1:0] sab;
  } sums_t;
endpackage

/* src/lagged_pearson_correlation.sv */
// top level of the lagged pearson correlation block
`timescale 1ns / 1ps
// streaming pearson correlation of two q1.15 channels with a lag of up to
// plus or minus 64 items (positive delays channel b). the front part takes one
// sample pair a cycle, pairs it through a 64-entry delay line and adds it to
// exact integer sums; on the transaction marked last it hands the sums to the
// back part through a one-entry hand-off register and clears for the next
// stream. the back part works out the variance and covariance terms with a
// bit-serial 64-bit multiplier (eight products) and then searches the
// coefficient one bit at a time (17 trials); the search is skipped when a
// variance is not positive. while a finished stream waits in the hand-off
// register for a busy back part, the front stalls every transaction; it also
// stalls for one cycle after the lag register changes.
// pair_count saturates at 65536; coefficient is 0 when a variance is not positive
module lagged_pearson_correlation (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic signed [7:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lpc_pkg::sample_t     sample_a,
  input  lpc_pkg::sample_t     sample_b,
  input  logic                 accept_a,
  input  logic                 accept_b,
  input  logic                 last,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [16:0]   coefficient,
  output logic [16:0]          pair_count
);
  import lpc_pkg::*;

  // lag register
  logic signed [7:0] lag;
  logic              q_valid, q_stall;
  sums_t             q_data;

  always_ff @(posedge clk) begin
    if (rst) lag <= '0;
    else if (cfg_we) lag <= cfg_data;
  end

  lpc_front u_front (
    .clk, .rst, .lag, .in_valid, .in_stall, .sample_a, .sample_b,
    .accept_a, .accept_b, .last, .q_valid, .q_stall, .q_data
  );

  lpc_back u_back (
    .clk, .rst, .q_valid, .q_stall, .q_data, .out_valid, .out_stall,
    .coefficient, .pair_count
  );
endmodule

/* src/lpc_front.sv */
// front part: delay line, pairing and running sums
`timescale 1ns / 1ps
module lpc_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic signed [7:0]          lag,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  lpc_pkg::sample_t           sample_a,
  input  lpc_pkg::sample_t           sample_b,
  input  logic                       accept_a,
  input  logic                       accept_b,
  input  logic                       last,
  output logic                       q_valid,
  input  logic                       q_stall,
  output lpc_pkg::sums_t             q_data
);
  import lpc_pkg::*;
  `include "lagged_pearson_correlation_macros.svh"

  // delay line memory with per-entry written flags (unwritten entries read as zero)
  logic [SampleBits:0] dline [MaxLag];
  logic [MaxLag-1:0]   dvalid;
  logic [LagW-1:0]     wpos;
  logic [MagW-1:0]     seen;
  sums_t               acc;
  logic                fire;

  // registered read of the entry that the next transaction pairs with
  logic [SampleBits:0] rd_data;
  logic                rd_vld;
  logic                rd_fwd;
  logic [SampleBits:0] fwd_data;
  logic signed [7:0]   rd_lag;

  logic signed [8:0]   lag_w;
  logic [MagW-1:0]     mag;
  logic                lpos;
  logic                wr_en;
  logic [SampleBits:0] wr_data;
  logic [LagW-1:0]     wpos_next;
  logic [LagW-1:0]     rpos_next;
  logic [SampleBits:0] old;
  sample_t             a, b;
  logic                aa, ab, have, use_pair;
  logic signed [2*SampleBits-1:0] paa, pbb, pab;
  sums_t               acc_next;

  always_comb begin
    lag_w = {lag[7], lag};
    if (lag_w > 9'(MaxLag)) lag_w = 9'(MaxLag);
    if (lag_w < -9'(MaxLag)) lag_w = -9'(MaxLag);
    lpos = !lag_w[8];
    mag  = lpos ? MagW'(lag_w) : MagW'(-lag_w);
    old  = rd_fwd ? fwd_data : (rd_vld ? rd_data : '0);
    a = sample_a; b = sample_b; aa = accept_a; ab = accept_b;
    have = 1'b1;
    if (mag != '0) begin
      have = seen >= mag;
      if (lpos) begin
        b = old[SampleBits-1:0]; ab = old[SampleBits];
      end else begin
        a = old[SampleBits-1:0]; aa = old[SampleBits];
      end
    end
    use_pair = have && aa && ab && (acc.n < CountW'(MaxRows));
    paa = a * a;
    pbb = b * b;
    pab = a * b;
    acc_next = acc;
    if (use_pair) begin
      acc_next.n   = acc.n + 1'b1;
      acc_next.sa  = acc.sa + SumW'(a);
      acc_next.sb  = acc.sb + SumW'(b);
      acc_next.saa = acc.saa + SqW'($unsigned(paa));
      acc_next.sbb = acc.sbb + SqW'($unsigned(pbb));
      acc_next.sab = acc.sab + CrossW'(pab);
    end
    wr_en   = fire && (mag != '0);
    wr_data = lpos ? {accept_b, sample_b} : {accept_a, sample_a};
    wpos_next = wpos;
    if (wr_en) wpos_next = wpos + 1'b1;
    if (fire && last) wpos_next = '0;
    rpos_next = wpos_next - LagW'(mag);
  end

  // hold off for one cycle after a lag change so the read is refetched
  assign in_stall = (q_valid && q_stall) || (rd_lag != lag);
  assign fire     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (wr_en) dline[wpos] <= wr_data;
    rd_data <= dline[rpos_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dvalid   <= '0;
      wpos     <= '0;
      seen     <= '0;
      acc      <= '0;
      q_valid  <= 1'b0;
      rd_vld   <= 1'b0;
      rd_fwd   <= 1'b0;
      fwd_data <= '0;
      rd_lag   <= '0;
    end else begin
      rd_lag   <= lag;
      rd_vld   <= dvalid[rpos_next];
      rd_fwd   <= wr_en && (rpos_next == wpos);
      fwd_data <= wr_data;
      if (wr_en) dvalid[wpos] <= 1'b1;
      wpos <= wpos_next;
      if (fire && last) begin
        q_data  <= acc_next;
        q_valid <= 1'b1;
        acc     <= '0;
        seen    <= '0;
      end else begin
        if (q_valid && !q_stall) q_valid <= 1'b0;
        if (fire) begin
          acc <= acc_next;
          if (seen < MagW'(MaxLag)) seen <= seen + 1'b1;
        end
      end
    end
  end

  `LPC_ASSERT_IMPL(a_cnt_cap, clk, rst, 1'b1, acc.n <= CountW'(MaxRows), "pair count over limit")
  `LPC_ASSERT_IMPL(a_seen_cap, clk, rst, 1'b1, seen <= MagW'(MaxLag), "items seen over limit")
  `LPC_ASSERT_NEXT(a_last_clr, clk, rst, fire && last, acc.n == '0, "sums not cleared")
endmodule

/* src/lpc_back.sv */
// back part: variance terms and bit-serial coefficient search
`timescale 1ns / 1ps
module lpc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_stall,
  input  lpc_pkg::sums_t       q_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [16:0]   coefficient,
  output logic [16:0]          pair_count
);
  import lpc_pkg::*;
  `include "lagged_pearson_correlation_macros.svh"

  localparam int W  = 64;
  localparam int BW = 192;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_PROD, S_RHS, S_SRCH, S_MULB, S_CMP, S_DONE} state_t;
  state_t state;

  sums_t            s;
  logic [2:0]       mstep;
  logic signed [W-1:0] d1, d2, num;
  logic [W-1:0]     m;
  logic [BW-1:0]    bd, rhs, lhs, mul_out;
  logic [BW-1:0]    mul_x;
  logic [W-1:0]     mul_y;
  logic [5:0]       mbit;
  logic             neg, zero;
  logic [15:0]      lo;
  logic [4:0]       bitn;
  logic [16:0]      cand;
  logic [17:0]      odd;
  logic [35:0]      odd_sq;

  // shift-and-add multiplier, one bit a cycle
  logic [BW-1:0] macc;
  logic          mbusy;

  assign q_stall = state != S_IDLE;
  // last trial is full scale, k = 32768
  assign cand    = (bitn == 5'd16) ? 17'd32768 : ({1'b0, lo} | (17'd1 << bitn));
  assign odd     = {cand, 1'b0} - 18'd1;
  assign odd_sq  = odd * odd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      mbusy     <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;
      if (mbusy) begin
        if (mul_y[0]) macc <= macc + mul_x;
        mul_x <= mul_x << 1;
        mul_y <= mul_y >> 1;
        mbit  <= mbit + 1'b1;
        if (mbit == 6'd63) mbusy <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            s     <= q_data;
            mstep <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          // small products done as sequential 64-bit multiplies
          if (!mbusy) begin
            mstep <= mstep + 1'b1;
            case (mstep)
              3'd0: begin mul_x <= BW'(s.n); mul_y <= W'(s.saa); end
              3'd1: begin d1 <= W'(macc); mul_x <= BW'(s.sa); mul_y <= W'(s.sa); end
              3'd2: begin d1 <= d1 - W'(macc); mul_x <= BW'(s.n); mul_y <= W'(s.sbb); end
              3'd3: begin d2 <= W'(macc); mul_x <= BW'(s.sb); mul_y <= W'(s.sb); end
              3'd4: begin d2 <= d2 - W'(macc); mul_x <= BW'(s.n); mul_y <= W'(s.sab); end
              3'd5: begin num <= W'(macc); mul_x <= BW'(s.sa); mul_y <= W'(s.sb); end
              default: begin
                num   <= num - W'(macc);
                state <= S_PROD;
              end
            endcase
            if (mstep != 3'd6) begin
              macc  <= '0;
              mbit  <= '0;
              mbusy <= 1'b1;
            end
          end
        end
        S_PROD: begin
          zero <= (d1 <= 0) || (d2 <= 0);
          neg  <= num[W-1];
          m    <= num[W-1] ? -num : num;
          mul_x <= BW'(d1); mul_y <= d2;
          macc <= '0; mbit <= '0; mbusy <= 1'b1;
          state <= S_RHS;
          mstep <= '0;
        end
        S_RHS: begin
          if (!mbusy) begin
            if (mstep == 3'd0) begin
              bd <= macc;
              mul_x <= BW'(m); mul_y <= m;
              macc <= '0; mbit <= '0; mbusy <= 1'b1;
              mstep <= 3'd1;
            end else begin
              rhs   <= macc << 32;
              lo    <= '0;
              bitn  <= 5'd15;
              state <= zero ? S_DONE : S_SRCH;
            end
          end
        end
        S_SRCH: begin
          // test one coefficient bit: (2k-1)^2 * bd <= rhs
          mul_x <= bd; mul_y <= W'(odd_sq);
          macc <= '0; mbit <= '0; mbusy <= 1'b1;
          state <= S_MULB;
        end
        S_MULB: begin
          if (!mbusy) state <= S_CMP;
        end
        S_CMP: begin
          if (bitn == 5'd16) begin
            state <= S_DONE;
            if (macc <= rhs) lo <= '0;
          end else begin
            if (macc <= rhs) lo <= cand[15:0];
            if (bitn == 5'd0) begin
              bitn  <= 5'd16;
              state <= S_SRCH;
            end else begin
              bitn  <= bitn - 1'b1;
              state <= S_SRCH;
            end
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            // full-scale case: top bit test gives k = 32768
            if (zero) coefficient <= '0;
            else if (bitn == 5'd16 && macc <= rhs)
              coefficient <= neg ? -17'sd32768 : 17'sd32768;
            else coefficient <= neg ? -$signed({1'b0, lo}) : $signed({1'b0, lo});
            pair_count <= 17'(s.n);
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `LPC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid, "result dropped")
  `LPC_ASSERT_IMPL(a_busy, clk, rst, mbusy, state != S_IDLE, "multiplier busy while idle")
  `LPC_ASSERT_IMPL(a_coef, clk, rst, out_valid,
    coefficient <= 17'sd32768 && coefficient >= -17'sd32768, "coefficient out of range")
endmodule

/* sim/lagged_pearson_correlation_tb.sv */
// self-checking testbench for the lagged pearson correlation block
`timescale 1ns / 1ps
module lagged_pearson_correlation_tb;
  import lpc_pkg::*;

  // a finished stream as the block should report it
  typedef struct {
    logic signed [16:0] coef;
    logic [16:0]        count;
  } stream_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic signed [7:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  sample_t sample_a = '0;
  sample_t sample_b = '0;
  logic accept_a = 1'b0;
  logic accept_b = 1'b0;
  logic last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic signed [16:0] coefficient;
  logic [16:0] pair_count;

  lagged_pearson_correlation uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .sample_a(sample_a), .sample_b(sample_b),
    .accept_a(accept_a), .accept_b(accept_b), .last(last),
    .out_valid(out_valid), .out_stall(out_stall),
    .coefficient(coefficient), .pair_count(pair_count)
  );

  always #5 clk = ~clk;

  // predictor state, mirrors the block's front part
  logic signed [7:0] lag_q = '0;
  logic [16:0] delay_q [MaxLag];
  int wr_pos, seen_cnt, pairs_cnt;
  longint acc_a, acc_b, acc_aa, acc_bb, acc_ab;
  stream_result_t pending_results[$];

  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int hold_req = 0;     // long receiver hold-off, taken by the receiver process
  bit quiet = 1'b0;     // no idling on either side while set

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    errors++;
  endtask

  // coefficient by search: largest k with (2k-1)^2*d1*d2 <= num^2*2^32
  function automatic logic signed [16:0] pearson_code();
    longint d1, d2, num;
    longint unsigned mag;
    logic [191:0] vprod, bound, trial;
    int lo, hi, mid;
    d1 = longint'(pairs_cnt) * acc_aa - acc_a * acc_a;
    d2 = longint'(pairs_cnt) * acc_bb - acc_b * acc_b;
    num = longint'(pairs_cnt) * acc_ab - acc_a * acc_b;
    if (d1 <= 0 || d2 <= 0) return '0;
    mag = (num < 0) ? -num : num;
    vprod = {128'b0, 64'(d1)} * {128'b0, 64'(d2)};
    bound = ({128'b0, mag} * {128'b0, mag}) << 32;
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      trial = 192'(longint'(2 * mid - 1) * longint'(2 * mid - 1)) * vprod;
      if (trial <= bound) lo = mid;
      else hi = mid - 1;
    end
    return (num < 0) ? 17'(-lo) : 17'(lo);
  endfunction

  function automatic void clear_stream_state();
    wr_pos = 0;
    seen_cnt = 0;
    pairs_cnt = 0;
    acc_a = 0; acc_b = 0; acc_aa = 0; acc_bb = 0; acc_ab = 0;
  endfunction

  // one accepted transaction through the predictor
  function automatic void predict_pair(input sample_t a_in, input sample_t b_in,
                                       input bit ok_a_in, input bit ok_b_in,
                                       input bit end_in);
    int l, m;
    logic [16:0] old;
    longint a, b;
    bit ok_a, ok_b, paired;
    stream_result_t r;
    a = a_in; b = b_in; ok_a = ok_a_in; ok_b = ok_b_in; paired = 1'b1;
    l = lag_q;
    if (l > MaxLag) l = MaxLag;
    if (l < -MaxLag) l = -MaxLag;
    m = (l < 0) ? -l : l;
    if (m != 0) begin
      old = delay_q[(wr_pos + MaxLag - m) % MaxLag];
      delay_q[wr_pos] = (l > 0) ? {ok_b_in, b_in} : {ok_a_in, a_in};
      wr_pos = (wr_pos + 1) % MaxLag;
      paired = (seen_cnt >= m);
      if (l > 0) begin
        b = longint'($signed(old[15:0])); ok_b = old[16];
      end else begin
        a = longint'($signed(old[15:0])); ok_a = old[16];
      end
    end
    if (seen_cnt < MaxLag) seen_cnt++;
    if (paired && ok_a && ok_b && pairs_cnt < MaxRows) begin
      pairs_cnt++;
      acc_a += a; acc_b += b;
      acc_aa += a * a; acc_bb += b * b; acc_ab += a * b;
    end
    if (end_in) begin
      r.coef = pearson_code();
      r.count = 17'(pairs_cnt);
      pending_results.push_back(r);
      clear_stream_state();
    end
  endfunction

  // one transaction on the input channel, with a random gap before it
  task automatic send_pair(input sample_t a, input sample_t b, input bit ok_a,
                           input bit ok_b, input bit end_flag);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    sample_a <= a; sample_b <= b;
    accept_a <= ok_a; accept_b <= ok_b; last <= end_flag;
    do @(posedge clk); while (in_stall);
    predict_pair(a, b, ok_a, ok_b, end_flag);
    items_sent++;
  endtask

  // drop valid and wait for every pending result, plus the back-end latency
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (1600) @(posedge clk);
  endtask

  task automatic write_lag(input logic signed [7:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    lag_q = v;
  endtask

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return sample_t'($urandom_range(0, 15)) - 16'sd8;
      default: return sample_t'($urandom);
    endcase
  endfunction

  // receiver: random stall before each result, long hold-off on request
  initial begin
    int w;
    @(negedge clk);
    forever begin
      if (hold_req > 0) begin
        out_stall <= 1'b1;
        repeat (hold_req) @(negedge clk);
        hold_req = 0;
      end
      w = quiet ? 0 : $urandom_range(0, 15);
      if (w != 0) begin
        out_stall <= 1'b1;
        repeat (w) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall) && hold_req == 0);
      @(negedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    stream_result_t e;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with no stream waiting");
      end else begin
        e = pending_results.pop_front();
        if (coefficient !== e.coef)
          report_mismatch($sformatf("coefficient %0d, expected %0d",
                                    coefficient, e.coef));
        if (pair_count !== e.count)
          report_mismatch($sformatf("pair_count %0d, expected %0d",
                                    pair_count, e.count));
      end
    end
  end

  // extremes, accept flags and the degenerate streams at lag zero
  task automatic test_directed_zero_lag();
    write_lag(8'sd0);
    send_pair(16'sh7fff, 16'sh8000, 1'b0, 1'b1, 1'b1);   // no pairs at all
    send_pair(16'sh1234, 16'sh4321, 1'b1, 1'b1, 1'b1);   // single pair, no variance
    send_pair(16'sh8000, 16'sh8000, 1'b1, 1'b1, 1'b0);   // perfect positive
    send_pair(16'sh7fff, 16'sh7fff, 1'b1, 1'b1, 1'b0);
    send_pair(16'sh0000, 16'sh0000, 1'b1, 1'b1, 1'b1);
    send_pair(16'sh8000, 16'sh7fff, 1'b1, 1'b1, 1'b0);   // perfect negative
    send_pair(16'sh7fff, 16'sh8000, 1'b1, 1'b1, 1'b0);
    send_pair(16'shffff, 16'sh5555, 1'b1, 1'b0, 1'b0);   // one flag low each way
    send_pair(16'sh5555, 16'shaaaa, 1'b0, 1'b1, 1'b1);
    send_pair(16'sh0100, 16'sh0007, 1'b1, 1'b1, 1'b0);   // constant channel b
    send_pair(16'shff00, 16'sh0007, 1'b1, 1'b1, 1'b1);
    drain();
  endtask

  // lag extremes, out-of-range lags and streams shorter than the lag
  task automatic test_lag_extremes();
    logic signed [7:0] lags [8] = '{8'sd64, -8'sd64, 8'sd127, -8'sd128,
                                    8'sd1, -8'sd1, 8'sd5, -8'sd3};
    foreach (lags[i]) begin
      write_lag(lags[i]);
      send_pair(rand_sample(), rand_sample(), 1'b1, 1'b1, 1'b0);
      send_pair(rand_sample(), rand_sample(), 1'b1, 1'b1, 1'b1);
      for (int k = 0; k < 70; k++)
        send_pair(rand_sample(), rand_sample(), $urandom_range(0, 7) != 0,
                  $urandom_range(0, 7) != 0, k == 69);
      drain();
    end
  endtask

  // receiver holds off long enough for streams to pile up and stall the input
  task automatic test_result_backpressure();
    write_lag(-8'sd2);
    hold_req = 6000;
    repeat (2) @(negedge clk);
    for (int s = 0; s < 5; s++)
      for (int k = 0; k < 4; k++)
        send_pair(rand_sample(), rand_sample(), 1'b1, 1'b1, k == 3);
    drain();
  endtask

  // random streams of random length, mostly well formed, lag changed between phases
  task automatic test_random_streams();
    int len, mode;
    sample_t a, b;
    for (int phase = 0; phase < 6; phase++) begin
      write_lag(8'($signed($urandom_range(0, 128)) - 64));
      quiet = (phase == 3);
      for (int s = 0; s < 8; s++) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120)
                                          : $urandom_range(1, 40);
        mode = $urandom_range(0, 3);
        for (int k = 0; k < len; k++) begin
          a = rand_sample();
          case (mode)
            0: b = a + sample_t'($urandom_range(0, 255)) - 16'sd128;
            1: b = -a + sample_t'($urandom_range(0, 63));
            default: b = rand_sample();
          endcase
          send_pair(a, b, $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0,
                    k == len - 1);
        end
      end
      drain();
    end
    quiet = 1'b0;
  endtask

  initial begin
    foreach (delay_q[i]) delay_q[i] = '0;
    clear_stream_state();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_zero_lag();
    test_lag_extremes();
    test_result_backpressure();
    test_random_streams();
    $display("covered %0d transactions and %0d streams: lag extremes, saturated lag,",
             items_sent, results_seen);
    $display("degenerate streams, result backpressure and random correlated streams");
    if (errors == 0 && pending_results.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // overall time limit
  initial begin
    #10_000_000;
    $display("timeout");
    $display("Simulation FAILED");
    $finish;
  end
endmodule
